@@ rtl/core/ptt_pkg.sv @@
// Shared types and constants of the periodic timer table.
`default_nettype none

package ptt_pkg;

  localparam int unsigned NumTimers = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned IdW       = 4;
  localparam int unsigned OpW       = 3;
  localparam int unsigned IdxW      = $clog2(NumTimers);

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_ALLOC      = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_SET_PERIOD = 3'd3,
    OP_ADD_DELAY  = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_SCAN       = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [IdW-1:0]    timer_id;
    logic [CountW-1:0] amount;
    logic              query;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] result_id;
    logic           ok;
    logic           fired;
    logic           in_use;
    logic           last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef struct packed {
    logic [IdxW-1:0]   raddr;
    logic [IdxW-1:0]   waddr;
    logic              cnt_we;
    logic [CountW-1:0] cnt_wdata;
    logic              per_we;
    logic [CountW-1:0] per_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/periodic_timer_table.sv @@
// Periodic timer table: opcoded command input, one or more results per command.
//
// The input channel takes one command (tick, allocate, release or query, set
// period, add delay, clear countdown, scan) per transfer; the output channel
// returns its results, the final one marked by last. Both channels use valid
// and stall; a transfer happens at a clock edge with valid high and stall low.
// A single-slot command is worked on in ST_OP, and its result is registered
// into the output register. Tick and scan walk the countdown and period
// memories, whose read port is registered, one slot per cycle, pausing only
// where a scan result meets a stalled output. Scan gives one result per
// due slot, or a single non-fired result when no slot is due.
// The input stalls while a command is being worked on; it is taken again as
// soon as the last result sits in the output register, even if that result
// still waits. A stalled output holds its result and pauses the scan walk
// when a due slot is found while the held result cannot go out.
// Reset frees every slot and zeroes every countdown at once; no clearing pass
// is needed, and the block takes a command in the first cycle after reset.
`default_nettype none

module periodic_timer_table (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ptt_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ptt_pkg::out_item_t      out_item_o
);

  logic                          busy;
  logic                          in_take;
  logic                          out_free;
  ptt_pkg::emit_t                emit;
  ptt_pkg::mem_req_t             mem_req;
  logic [ptt_pkg::CountW-1:0]    cnt_rdata;
  logic [ptt_pkg::CountW-1:0]    per_rdata;
  logic                          out_valid_q;
  ptt_pkg::out_item_t            out_item_q;

  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_item_i   (in_item_i),
    .out_free_i  (out_free),
    .cnt_rdata_i (cnt_rdata),
    .per_rdata_i (per_rdata),
    .busy_o      (busy),
    .emit_o      (emit),
    .mem_o       (mem_req)
  );

  ptt_ram #(
    .Depth (ptt_pkg::NumTimers),
    .Width (ptt_pkg::CountW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.cnt_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.cnt_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (cnt_rdata)
  );

  ptt_ram #(
    .Depth (ptt_pkg::NumTimers),
    .Width (ptt_pkg::CountW)
  ) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.per_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.per_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (per_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_item_q <= emit.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> out_free)
    else $error("result produced while the output register is occupied");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> busy)
    else $error("command accepted but the sequencer did not start");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.item.last) |=> !busy)
    else $error("sequencer still busy after the final result");

  a_ok_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.item.ok) |-> (emit.item.in_use && !emit.item.fired && emit.item.last))
    else $error("successful allocation result has inconsistent flags");

endmodule

`default_nettype wire

@@ rtl/core/ptt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ptt_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/ptt_ctrl.sv @@
// Sequencer of the timer table: in-use bits, countdown valid bits and memory sweeps.
`default_nettype none

module ptt_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_take_i,
  input  wire ptt_pkg::in_item_t             in_item_i,
  input  wire logic                          out_free_i,
  input  wire logic [ptt_pkg::CountW-1:0]    cnt_rdata_i,
  input  wire logic [ptt_pkg::CountW-1:0]    per_rdata_i,
  output logic                               busy_o,
  output ptt_pkg::emit_t                     emit_o,
  output ptt_pkg::mem_req_t                  mem_o
);

  ptt_pkg::state_e state_q, state_d;

  logic [ptt_pkg::OpW-1:0]     op_q;
  logic [ptt_pkg::IdW-1:0]     id_q;
  logic [ptt_pkg::CountW-1:0]  amt_q;
  logic                        qry_q;

  logic [ptt_pkg::IdxW-1:0]    ptr_q, ptr_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [ptt_pkg::IdxW-1:0]    pend_id_q, pend_id_d;
  logic [ptt_pkg::NumTimers-1:0] used_q, used_d;
  logic [ptt_pkg::NumTimers-1:0] cvalid_q, cvalid_d;

  logic                        id_ok;
  logic [ptt_pkg::IdxW-1:0]    id_idx;
  logic [ptt_pkg::IdxW-1:0]    cur_idx;
  logic [ptt_pkg::CountW-1:0]  cnt_cur;
  logic                        free_found;
  logic [ptt_pkg::IdxW-1:0]    free_idx;
  logic                        in_sweep_op;
  logic                        due;
  logic                        need_emit;
  logic                        advance;

  assign id_ok  = ({1'b0, id_q} < (ptt_pkg::IdW + 1)'(ptt_pkg::NumTimers));
  assign id_idx = id_q[ptt_pkg::IdxW-1:0];
  assign cur_idx = (state_q == ptt_pkg::ST_SWEEP) ? ptr_q : id_idx;
  // A countdown that was never written since reset, or was cleared, reads as zero.
  assign cnt_cur = cvalid_q[cur_idx] ? cnt_rdata_i : '0;
  assign busy_o  = (state_q != ptt_pkg::ST_IDLE);

  assign in_sweep_op = (in_item_i.opcode == ptt_pkg::OP_TICK) ||
                       (in_item_i.opcode == ptt_pkg::OP_SCAN);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptt_pkg::NumTimers - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = ptt_pkg::IdxW'(i);
      end
    end
  end

  assign due       = used_q[ptr_q] && (cnt_cur == '0);
  assign need_emit = (op_q == ptt_pkg::OP_SCAN) && due && pend_valid_q;
  assign advance   = !need_emit || out_free_i;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    used_d       = used_q;
    cvalid_d     = cvalid_q;
    emit_o       = '0;
    mem_o        = '0;
    mem_o.raddr  = cur_idx;

    case (state_q)
      ptt_pkg::ST_IDLE: begin
        mem_o.raddr = in_sweep_op ? '0 : in_item_i.timer_id[ptt_pkg::IdxW-1:0];
        if (in_take_i) begin
          state_d      = in_sweep_op ? ptt_pkg::ST_SWEEP : ptt_pkg::ST_OP;
          ptr_d        = '0;
          pend_valid_d = 1'b0;
        end
      end

      ptt_pkg::ST_OP: begin
        if (out_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.item.last = 1'b1;
          mem_o.waddr      = id_idx;
          state_d          = ptt_pkg::ST_IDLE;
          case (op_q)
            ptt_pkg::OP_ALLOC: begin
              if (free_found) begin
                used_d[free_idx]   = 1'b1;
                cvalid_d[free_idx] = 1'b0;
                mem_o.waddr        = free_idx;
                mem_o.per_we       = 1'b1;
                mem_o.per_wdata    = amt_q;
              end
            end
            ptt_pkg::OP_RELEASE: begin
              if (id_ok && !qry_q) begin
                used_d[id_idx] = 1'b0;
              end
            end
            ptt_pkg::OP_SET_PERIOD: begin
              mem_o.per_we    = id_ok;
              mem_o.per_wdata = amt_q;
            end
            ptt_pkg::OP_ADD_DELAY: begin
              if (id_ok) begin
                mem_o.cnt_we     = 1'b1;
                mem_o.cnt_wdata  = cnt_cur + amt_q;
                cvalid_d[id_idx] = 1'b1;
              end
            end
            ptt_pkg::OP_CLEAR: begin
              if (id_ok) begin
                cvalid_d[id_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
          if (op_q == ptt_pkg::OP_ALLOC) begin
            emit_o.item.result_id = free_found ? ptt_pkg::IdW'(free_idx) : '0;
            emit_o.item.ok        = free_found;
            emit_o.item.in_use    = free_found;
          end else begin
            emit_o.item.result_id = id_q;
            emit_o.item.in_use    = id_ok && used_d[id_idx];
          end
        end
      end

      ptt_pkg::ST_SWEEP: begin
        if (advance) begin
          mem_o.waddr = ptr_q;
          mem_o.raddr = ptr_q + 1'b1;
          if (op_q == ptt_pkg::OP_SCAN) begin
            if (due) begin
              mem_o.cnt_we    = 1'b1;
              mem_o.cnt_wdata = per_rdata_i;
              cvalid_d[ptr_q] = 1'b1;
              pend_valid_d    = 1'b1;
              pend_id_d       = ptr_q;
            end
            // A due slot found while one is already held releases the held one,
            // which is then known not to be the final result.
            if (need_emit) begin
              emit_o.valid          = 1'b1;
              emit_o.item.result_id = ptt_pkg::IdW'(pend_id_q);
              emit_o.item.fired     = 1'b1;
              emit_o.item.in_use    = 1'b1;
            end
          end else if (cnt_cur != '0) begin
            mem_o.cnt_we    = 1'b1;
            mem_o.cnt_wdata = cnt_cur - 1'b1;
          end
          if (ptr_q == ptt_pkg::IdxW'(ptt_pkg::NumTimers - 1)) begin
            state_d = ptt_pkg::ST_FINISH;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end

      ptt_pkg::ST_FINISH: begin
        if (out_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.item.last = 1'b1;
          if (op_q == ptt_pkg::OP_SCAN) begin
            if (pend_valid_q) begin
              emit_o.item.result_id = ptt_pkg::IdW'(pend_id_q);
              emit_o.item.fired     = 1'b1;
              emit_o.item.in_use    = 1'b1;
            end
          end else begin
            emit_o.item.result_id = id_q;
            emit_o.item.in_use    = id_ok && used_q[id_idx];
          end
          pend_valid_d = 1'b0;
          state_d      = ptt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptt_pkg::ST_IDLE;
      ptr_q        <= '0;
      pend_valid_q <= 1'b0;
      used_q       <= '0;
      cvalid_q     <= '0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      pend_valid_q <= pend_valid_d;
      used_q       <= used_d;
      cvalid_q     <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (in_take_i) begin
      op_q  <= in_item_i.opcode;
      id_q  <= in_item_i.timer_id;
      amt_q <= in_item_i.amount;
      qry_q <= in_item_i.query;
    end
  end

endmodule

`default_nettype wire
